### rtl/fbfl_pkg.sv
// shared types and constants of the block pool allocator
package fbfl_pkg;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int OFF_W    = 22;
  localparam int IDX_W    = 10;
  localparam int PB_W     = 11;
  localparam int BB_W     = 13;
  localparam int SIZE_W   = BB_W + 1;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = BB_W;

  localparam int MIN_BLOCK_BYTES = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_OFF  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_INIT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

  // shared arithmetic unit operations
  localparam logic ARITH_MUL = 1'b0;
  localparam logic ARITH_DIV = 1'b1;

  typedef struct packed {
    logic              go;
    logic              op;
    logic [OFF_W-1:0]  a;
    logic [SIZE_W-1:0] b;
  } arith_cmd_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] acc;
    logic [OFF_W-1:0] sh;
  } arith_rsp_t;

endpackage

### rtl/fbfl_arith.sv
// shared shift-add multiplier and restoring divider, one bit per cycle
module fbfl_arith (
  input  logic                clk,
  input  logic                rst,
  input  fbfl_pkg::arith_cmd_t cmd,
  output fbfl_pkg::arith_rsp_t rsp
);
  import fbfl_pkg::*;

  localparam int AW    = OFF_W + 1;
  localparam int CNT_W = $clog2(OFF_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OFF_W - 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic              op;
  logic [SIZE_W-1:0] b;
  logic [OFF_W-1:0]  acc;
  logic [OFF_W-1:0]  sh;

  logic [AW-1:0] x;
  logic [AW-1:0] y;
  logic          sub;
  logic [AW:0]   s;
  logic          no_borrow;

  // operand select for the single adder
  always_comb begin
    if (op == ARITH_DIV) begin
      x   = {acc, sh[OFF_W-1]};
      y   = AW'(b);
      sub = 1'b1;
    end else begin
      x   = {1'b0, acc[OFF_W-2:0], 1'b0};
      y   = sh[OFF_W-1] ? AW'(b) : '0;
      sub = 1'b0;
    end
    s = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (AW+1)'(sub);
    no_borrow = s[AW];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder or product in acc, quotient or multiplier in sh
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      op  <= cmd.op;
      b   <= cmd.b;
      acc <= '0;
      sh  <= cmd.a;
    end else if (busy) begin
      if (op == ARITH_DIV) begin
        acc <= no_borrow ? s[OFF_W-1:0] : x[OFF_W-1:0];
        sh  <= {sh[OFF_W-2:0], no_borrow};
      end else begin
        acc <= s[OFF_W-1:0];
        sh  <= {sh[OFF_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.acc  = acc;
  assign rsp.sh   = sh;

endmodule

### rtl/fbfl_link_ram.sv
// link store: one write port, one registered read port
module fbfl_link_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fixed_block_free_list_allocator_core.sv
// block pool allocator top level: sequencer, counters and list head
//
// Command channel: an item (func, free_offset) is taken at a rising edge with
// start high and busy low. Busy stays high until the result is ready; one
// item is worked on at a time. Each result is shown for one cycle with done
// high, and the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready write pool_blocks (index 0) or
// block_bytes (index 1); cfg_ready is always high. Both are sampled by init.
// Sequence from accept to done:
//   allocate and free: the shared unit computes one
//     bit of the block offset product or of the offset quotient per cycle
//     over 22 steps, then the reply state
//   init: one link store entry written per cycle, then the reply state
//   rejected items (not initialised, empty pool, bad config, func 3): reply state only
// A new item may be accepted in the cycle that done is high.
// Reset clears the list head, used count and ready flag and loads the
// register defaults; the link store is not cleared and is rebuilt by init.
module fixed_block_free_list_allocator_core #(
  parameter int POOL_DEPTH      = 1024,
  parameter int ALIGN_BYTES     = 16,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [fbfl_pkg::FUNC_W-1:0]         func,
  input  logic [fbfl_pkg::OFF_W-1:0]          free_offset,
  output logic                                done,
  output logic [fbfl_pkg::STAT_W-1:0]         status,
  output logic [fbfl_pkg::IDX_W-1:0]          block_index,
  output logic [fbfl_pkg::OFF_W-1:0]          block_offset,
  output logic [fbfl_pkg::PB_W-1:0]           blocks_used,
  output logic [fbfl_pkg::PB_W-1:0]           free_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fbfl_pkg::*;

  localparam int LW  = $clog2(POOL_DEPTH + 1);
  localparam int AIW = $clog2(POOL_DEPTH);
  localparam int CW  = (LW > PB_W) ? LW : PB_W;
  localparam logic [LW-1:0] END_MARK = LW'(POOL_DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_FREE  = 3'd3;
  localparam logic [2:0] ST_REPLY = 3'd4;

  logic [2:0]        state;
  logic [PB_W-1:0]   pool_blocks;
  logic [BB_W-1:0]   block_bytes;
  logic [PB_W-1:0]   held_blocks;
  logic [SIZE_W-1:0] held_size;
  logic [LW-1:0]     head;
  logic [LW-1:0]     used;
  logic              pool_ready;
  logic [AIW-1:0]    sw_cnt;
  logic [OFF_W-1:0]  off_q;
  logic [STAT_W-1:0] r_status;
  logic [IDX_W-1:0]  r_index;
  logic [OFF_W-1:0]  r_offset;

  arith_cmd_t        acmd;
  arith_rsp_t        arsp;
  logic              ram_we;
  logic [AIW-1:0]    ram_waddr;
  logic [LW-1:0]     ram_wdata;
  logic              ram_re;
  logic [LW-1:0]     ram_rdata;

  logic              accept;
  logic              cfg_bad;
  logic              head_ok;
  logic              sweep_last;
  logic              free_ok;
  logic [SIZE_W-1:0] size_rnd;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // config checks and aligned size
  assign cfg_bad = (pool_blocks == '0) || (32'(pool_blocks) > POOL_DEPTH) ||
                   (32'(block_bytes) < MIN_BLOCK_BYTES) ||
                   (32'(block_bytes) > MAX_BLOCK_BYTES);
  assign size_rnd = (SIZE_W'(block_bytes) + SIZE_W'(ALIGN_BYTES - 1)) &
                    ~SIZE_W'(ALIGN_BYTES - 1);

  assign head_ok    = (head < END_MARK) && (CW'(head) < CW'(held_blocks));
  assign sweep_last = (CW'(sw_cnt) == CW'(held_blocks - 1'b1));
  assign free_ok    = (arsp.acc == '0) && (arsp.sh < OFF_W'(held_blocks));

  // shared unit command: offset product for allocate, quotient for free
  always_comb begin
    acmd.go = accept && pool_ready &&
              (((func == FUNC_ALLOC) && head_ok) || (func == FUNC_FREE));
    acmd.op = (func == FUNC_FREE) ? ARITH_DIV : ARITH_MUL;
    acmd.a  = (func == FUNC_FREE) ? free_offset : OFF_W'(head);
    acmd.b  = held_size;
  end

  // link store access
  always_comb begin
    ram_re    = accept && pool_ready && (func == FUNC_ALLOC) && head_ok;
    ram_we    = 1'b0;
    ram_waddr = sw_cnt;
    ram_wdata = sweep_last ? END_MARK : (LW'(sw_cnt) + 1'b1);
    if (state == ST_INIT) begin
      ram_we = 1'b1;
    end else if ((state == ST_FREE) && arsp.done && free_ok) begin
      ram_we    = 1'b1;
      ram_waddr = arsp.sh[AIW-1:0];
      ram_wdata = head;
    end
  end

  fbfl_arith u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (acmd),
    .rsp (arsp)
  );

  fbfl_link_ram #(
    .DEPTH (POOL_DEPTH),
    .DW    (LW)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head[AIW-1:0]),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_blocks <= PB_W'(1024);
      block_bytes <= BB_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POOL_BLOCKS: pool_blocks <= cfg_data[PB_W-1:0];
        REG_BLOCK_BYTES: block_bytes <= cfg_data[BB_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      used        <= '0;
      pool_ready  <= 1'b0;
      held_blocks <= '0;
      held_size   <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            off_q    <= free_offset;
            r_status <= STAT_OK;
            r_index  <= '0;
            r_offset <= '0;
            state    <= ST_REPLY;
            if (func == FUNC_INIT) begin
              if (cfg_bad) begin
                r_status <= STAT_NOT_INIT;
              end else begin
                held_blocks <= pool_blocks;
                held_size   <= size_rnd;
                head        <= '0;
                used        <= '0;
                pool_ready  <= 1'b1;
                sw_cnt      <= '0;
                state       <= ST_INIT;
              end
            end else if (!pool_ready) begin
              r_status <= STAT_NOT_INIT;
            end else if (func == FUNC_ALLOC) begin
              if (head_ok) begin
                state <= ST_ALLOC;
              end else begin
                r_status <= STAT_EMPTY;
              end
            end else if (func == FUNC_FREE) begin
              state <= ST_FREE;
            end
          end
        end
        ST_INIT: begin
          sw_cnt <= sw_cnt + 1'b1;
          if (sweep_last) begin
            state <= ST_REPLY;
          end
        end
        ST_ALLOC: begin
          if (arsp.done) begin
            head     <= ram_rdata;
            r_index  <= IDX_W'(head);
            r_offset <= arsp.acc;
            if (CW'(used) < CW'(held_blocks)) begin
              used <= used + 1'b1;
            end
            state <= ST_REPLY;
          end
        end
        ST_FREE: begin
          if (arsp.done) begin
            if (free_ok) begin
              head     <= LW'(arsp.sh);
              r_index  <= IDX_W'(arsp.sh);
              r_offset <= off_q;
              if (used != '0) begin
                used <= used - 1'b1;
              end
            end else begin
              r_status <= STAT_BAD_OFF;
            end
            state <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result registers, counts taken after the operation
  always_ff @(posedge clk) begin
    if (state == ST_REPLY) begin
      status       <= r_status;
      block_index  <= r_index;
      block_offset <= r_offset;
      blocks_used  <= PB_W'(used);
      if (pool_ready && (CW'(held_blocks) >= CW'(used))) begin
        free_count <= PB_W'(CW'(held_blocks) - CW'(used));
      end else begin
        free_count <= '0;
      end
    end
  end

endmodule

### tb/sv/fbfl_pool_checker.sv
// pool allocator checker: predicts every command result and compares it with the block
module fbfl_pool_checker #(
  parameter int POOL_DEPTH      = 1024,
  parameter int ALIGN_BYTES     = 16,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [fbfl_pkg::FUNC_W-1:0]     func,
  input  logic [fbfl_pkg::OFF_W-1:0]      free_offset,
  input  logic                            done,
  input  logic [fbfl_pkg::STAT_W-1:0]     status,
  input  logic [fbfl_pkg::IDX_W-1:0]      block_index,
  input  logic [fbfl_pkg::OFF_W-1:0]      block_offset,
  input  logic [fbfl_pkg::PB_W-1:0]       blocks_used,
  input  logic [fbfl_pkg::PB_W-1:0]       free_count,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen,
  output int                              empty_seen,
  output int                              refused_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  localparam logic [PB_W-1:0] END_MARK = PB_W'(POOL_DEPTH);
  localparam int AIW = $clog2(POOL_DEPTH);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [OFF_W-1:0]  offset;
    logic [PB_W-1:0]   used;
    logic [PB_W-1:0]   avail;
  } pool_result_t;

  // shadow of the pool state
  logic [PB_W-1:0]   next_free [POOL_DEPTH];
  logic [PB_W-1:0]   head_idx;
  logic [PB_W-1:0]   in_use;
  logic [PB_W-1:0]   held_count;
  logic [SIZE_W-1:0] held_size;
  logic              is_ready;
  logic [PB_W-1:0]   reg_pool;
  logic [BB_W-1:0]   reg_bytes;

  pool_result_t expected_results [$];

  // build a result from the current counts
  function automatic pool_result_t pool_result(input logic [STAT_W-1:0] st,
                                               input int unsigned idx,
                                               input int unsigned off);
    pool_result_t r;
    r.status = st;
    r.index  = IDX_W'(idx);
    r.offset = OFF_W'(off);
    r.used   = in_use;
    r.avail  = (is_ready && held_count >= in_use) ? held_count - in_use : '0;
    return r;
  endfunction

  // apply one command to the shadow state and give its result
  task automatic apply_pool_op(input logic [FUNC_W-1:0] f, input logic [OFF_W-1:0] off,
                               output pool_result_t r);
    int unsigned idx;
    int unsigned total;
    int unsigned off_u;
    int unsigned size_u;
    off_u  = 32'(off);
    size_u = 32'(held_size);
    total  = size_u * held_count;
    if (f == FUNC_INIT) begin
      if (reg_pool == 0 || reg_pool > POOL_DEPTH || reg_bytes < MIN_BLOCK_BYTES ||
          reg_bytes > MAX_BLOCK_BYTES) begin
        r = pool_result(STAT_NOT_INIT, 0, 0);
      end else begin
        held_count = reg_pool;
        held_size  = SIZE_W'((int'(reg_bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);
        for (int i = 0; i < held_count; i++) begin
          next_free[AIW'(i)] = (i + 1 < held_count) ? PB_W'(i + 1) : END_MARK;
        end
        head_idx = '0;
        in_use   = '0;
        is_ready = 1'b1;
        r = pool_result(STAT_OK, 0, 0);
      end
    end else if (!is_ready) begin
      r = pool_result(STAT_NOT_INIT, 0, 0);
    end else begin
      case (f)
        FUNC_ALLOC: begin
          idx = 32'(head_idx);
          if (idx >= POOL_DEPTH || idx >= held_count) begin
            r = pool_result(STAT_EMPTY, 0, 0);
          end else begin
            head_idx = next_free[idx[AIW-1:0]];
            if (in_use < held_count) in_use = in_use + 1'b1;
            r = pool_result(STAT_OK, idx, idx * size_u);
          end
        end
        FUNC_FREE: begin
          if (size_u == 0 || off_u >= total || (off_u % size_u) != 0) begin
            r = pool_result(STAT_BAD_OFF, 0, 0);
          end else begin
            idx = off_u / size_u;
            if (idx >= POOL_DEPTH) begin
              r = pool_result(STAT_BAD_OFF, 0, 0);
            end else begin
              next_free[idx[AIW-1:0]] = head_idx;
              head_idx = PB_W'(idx);
              if (in_use > 0) in_use = in_use - 1'b1;
              r = pool_result(STAT_OK, idx, off_u);
            end
          end
        end
        // spare code: no state change
        default: begin
          r = pool_result(STAT_OK, 0, 0);
        end
      endcase
    end
  endtask

  task automatic report_fault(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_fault($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    end
  endtask

  // sample channels at the rising edge: results first, then register writes, then items
  always @(posedge clk) begin : monitor
    pool_result_t want;
    pool_result_t next_want;
    if (rst) begin
      head_idx   = '0;
      in_use     = '0;
      held_count = '0;
      held_size  = '0;
      is_ready   = 1'b0;
      reg_pool   = PB_W'(1024);
      reg_bytes  = BB_W'(16);
      expected_results.delete();
      fail_count   = 0;
      results_seen = 0;
      empty_seen   = 0;
      refused_seen = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_fault($sformatf("result with nothing waiting, status %0d index %0d",
                                 status, block_index));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(status), 32'(want.status));
          check_field("block_index", 32'(block_index), 32'(want.index));
          check_field("block_offset", 32'(block_offset), 32'(want.offset));
          check_field("blocks_used", 32'(blocks_used), 32'(want.used));
          check_field("free_count", 32'(free_count), 32'(want.avail));
          if (want.status == STAT_EMPTY) empty_seen++;
          if (want.status == STAT_BAD_OFF) refused_seen++;
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POOL_BLOCKS) reg_pool = cfg_data[PB_W-1:0];
        else reg_bytes = cfg_data[BB_W-1:0];
      end
      if (start && !busy) begin
        apply_pool_op(func, free_offset, next_want);
        expected_results.push_back(next_want);
      end
    end
    pending = expected_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// testbench top of the block pool allocator: stimulus, watchdog and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  localparam int ALIGN       = 16;
  localparam int STALL_LIMIT = 8000;

  // operation code with no defined function
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     func;
  logic [OFF_W-1:0]      free_offset;
  logic                  done;
  logic [STAT_W-1:0]     status;
  logic [IDX_W-1:0]      block_index;
  logic [OFF_W-1:0]      block_offset;
  logic [PB_W-1:0]       blocks_used;
  logic [PB_W-1:0]       free_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int results_seen;
  int empty_seen;
  int refused_seen;

  // stimulus bookkeeping
  logic [OFF_W-1:0]  live_offsets [$];
  logic [FUNC_W-1:0] issued_funcs [$];
  int unsigned       cur_pool;
  int unsigned       cur_size;
  int                no_idle_left;
  int                inits_sent;
  int                quiet_cycles;

  fixed_block_free_list_allocator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .free_offset  (free_offset),
    .done         (done),
    .status       (status),
    .block_index  (block_index),
    .block_offset (block_offset),
    .blocks_used  (blocks_used),
    .free_count   (free_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  fbfl_pool_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .free_offset  (free_offset),
    .done         (done),
    .status       (status),
    .block_index  (block_index),
    .block_offset (block_offset),
    .blocks_used  (blocks_used),
    .free_count   (free_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .empty_seen   (empty_seen),
    .refused_seen (refused_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // keep the offsets handed out by allocate so that most frees are legal
  always @(posedge clk) begin : offset_tracker
    logic [FUNC_W-1:0] f;
    if (!rst) begin
      if (done && issued_funcs.size() > 0) begin
        f = issued_funcs.pop_front();
        if (status == STAT_OK && f == FUNC_ALLOC) live_offsets.push_back(block_offset);
        if (status == STAT_OK && f == FUNC_INIT) live_offsets.delete();
      end
      if (start && !busy) issued_funcs.push_back(func);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // idle gap before an item: mostly none, some short, a few long, with idle-free runs
  function automatic int pick_gap();
    int r;
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_idle_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called and returning at a falling edge; start stays high for back-to-back items
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [OFF_W-1:0] off);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    free_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (f == FUNC_INIT) inits_sent++;
  endtask

  // drop start and wait until every result is in and the block is idle
  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_POOL_BLOCKS) cur_pool = 32'(data[PB_W-1:0]);
    else cur_size = (int'(data) + ALIGN - 1) / ALIGN * ALIGN;
  endtask

  task automatic set_pool(input logic [CFG_DATA_W-1:0] pb, input logic [CFG_DATA_W-1:0] bb);
    settle();
    write_reg(REG_POOL_BLOCKS, pb);
    write_reg(REG_BLOCK_BYTES, bb);
  endtask

  function automatic int unsigned pick_pool(input int ph);
    int r;
    if (ph == 1) return 1024;
    if (ph == 2) return 1;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(2, 24);
    if (r < 90) return $urandom_range(25, 200);
    return $urandom_range(201, 1024);
  endfunction

  function automatic int unsigned pick_bytes(input int ph);
    if (ph == 1) return 4096;
    if (ph == 2) return 4;
    if ($urandom_range(0, 9) < 7) return $urandom_range(4, 64);
    return $urandom_range(65, 4096);
  endfunction

  // free offset: mostly a block that is out, sometimes a double free, else noise
  function automatic logic [OFF_W-1:0] pick_free_offset();
    logic [OFF_W-1:0] pick;
    int unsigned      sz;
    int               r;
    int               k;
    sz = (cur_size == 0) ? ALIGN : cur_size;
    r  = $urandom_range(0, 99);
    if (live_offsets.size() > 0 && r < 75) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      pick = live_offsets[k];
      live_offsets.delete(k);
      return pick;
    end
    if (live_offsets.size() > 0 && r < 85) begin
      return live_offsets[$urandom_range(0, live_offsets.size() - 1)];
    end
    case ($urandom_range(0, 2))
      0: pick = OFF_W'($urandom());
      1: pick = OFF_W'($urandom_range(0, cur_pool + 3) * sz);
      default: pick = OFF_W'($urandom_range(0, cur_pool) * sz + $urandom_range(1, sz - 1));
    endcase
    return pick;
  endfunction

  initial begin : stimulus
    int                    n;
    int                    bias;
    int                    r;
    logic [CFG_DATA_W-1:0] pb_data;
    rst          = 1'b1;
    start        = 1'b0;
    func         = FUNC_INIT;
    free_offset  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_POOL_BLOCKS;
    cfg_data     = '0;
    no_idle_left = 0;
    inits_sent   = 0;
    cur_pool     = 1024;
    cur_size     = 16;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // commands before the first init are refused
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_FREE, '0);
    send_item(FUNC_SPARE, '1);
    // init with a zero pool size is ignored
    set_pool('0, CFG_DATA_W'(16));
    send_item(FUNC_INIT, '0);

    // single block pool: empty pool, double free and used count saturation
    set_pool(CFG_DATA_W'(1), CFG_DATA_W'(4));
    send_item(FUNC_INIT, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_FREE, '0);
    send_item(FUNC_FREE, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, '0);
    // misaligned, past the end, and the largest offset
    send_item(FUNC_FREE, OFF_W'(8));
    send_item(FUNC_FREE, OFF_W'(16));
    send_item(FUNC_FREE, '1);
    send_item(FUNC_SPARE, '0);

    // bad settings at init once ready: counts are reported, state kept
    set_pool('1, CFG_DATA_W'(16));
    send_item(FUNC_INIT, '0);
    set_pool(CFG_DATA_W'(1), '1);
    send_item(FUNC_INIT, '0);
    set_pool(CFG_DATA_W'(1), CFG_DATA_W'(3));
    send_item(FUNC_INIT, '0);

    // largest pool with the largest block
    set_pool(CFG_DATA_W'(1024), CFG_DATA_W'(4096));
    send_item(FUNC_INIT, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_FREE, OFF_W'(1023 * 4096));
    send_item(FUNC_FREE, '1);
    send_item(FUNC_ALLOC, '0);

    // random phases, each under its own pool setting
    for (int ph = 0; ph < 8; ph++) begin
      // now and then an init under a setting that may be out of range
      if ($urandom_range(0, 3) == 0) begin
        settle();
        if ($urandom_range(0, 1) == 1) begin
          write_reg(REG_POOL_BLOCKS,
                    ($urandom_range(0, 1) == 1) ? '0 : CFG_DATA_W'($urandom_range(1025, 8191)));
        end else begin
          write_reg(REG_BLOCK_BYTES, ($urandom_range(0, 1) == 1) ?
                    CFG_DATA_W'($urandom_range(0, 3)) : CFG_DATA_W'($urandom_range(4097, 8191)));
        end
        send_item(FUNC_INIT, OFF_W'($urandom()));
      end
      pb_data = CFG_DATA_W'(pick_pool(ph));
      // upper data bits are outside the pool size register
      if ($urandom_range(0, 4) == 0) begin
        pb_data[CFG_DATA_W-1:PB_W] = (CFG_DATA_W-PB_W)'($urandom_range(0, 3));
      end
      set_pool(pb_data, CFG_DATA_W'(pick_bytes(ph)));
      send_item(FUNC_INIT, OFF_W'($urandom()));
      n    = $urandom_range(105, 125);
      bias = $urandom_range(30, 75);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) send_item(FUNC_INIT, OFF_W'($urandom()));
        else if (r < 5) send_item(FUNC_SPARE, OFF_W'($urandom()));
        else if (r < 5 + bias) send_item(FUNC_ALLOC, OFF_W'($urandom()));
        else send_item(FUNC_FREE, pick_free_offset());
      end
    end

    settle();
    repeat (30) @(negedge clk);
    $display("covered %0d results over %0d inits: %0d pool-empty, %0d refused frees",
             results_seen, inits_sent, empty_seen, refused_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
